>>> hw/rtl/psc_pkg.sv
// Shared types, constants and a helper function of the polyalphabetic shift cipher.
package psc_pkg;

    localparam int DEF_SHIFT_ENTRIES    = 64;
    localparam int DEF_SEQUENCE_ENTRIES = 64;

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [5:0] ALPHABET      = 6'd26;   // 'z' - 'a' + 1

    localparam int CHAR_W  = 8;
    localparam int SHIFT_W = 5;
    localparam int SLOT_W  = 6;
    localparam int LEN_CFG_W = 7;
    localparam int CFG_W   = 7;

    typedef enum logic [1:0] {
        CMD_CHAR    = 2'd0,
        CMD_SHIFT   = 2'd1,
        CMD_SEQ     = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_t;

    typedef enum logic [0:0] {
        CFG_DECRYPT = 1'b0,
        CFG_SEQ_LEN = 1'b1
    } cfg_idx_t;

    // Rotation request handed to the letter rotator.
    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic [SHIFT_W-1:0] shift;
        logic               decrypt;
    } psc_rot_req_t;

    // Signed byte reduced into 0..25. Bias by 5*26 keeps it positive, then
    // divide by 26 through the reciprocal 79/2048 (exact for x < 258).
    function automatic logic [SHIFT_W-1:0] mod26(input logic signed [7:0] v);
        logic [8:0]  x;
        logic [15:0] prod;
        logic [4:0]  q;
        logic [8:0]  qm;
        logic [8:0]  r;
        x    = 9'(v + 9'sd130);
        prod = 16'(x) * 16'd79;
        q    = prod[15:11];
        qm   = 9'(q) * 9'd26;
        r    = x - qm;
        return r[SHIFT_W-1:0];
    endfunction

endpackage

>>> hw/rtl/psc_ram.sv
// Generic single-write, single-read RAM with registered, read-enabled output.
module psc_ram
    import psc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/psc_rotate.sv
// Rotates an ASCII letter within its case by a shift, forward or backward; other bytes pass unchanged.
module psc_rotate
    import psc_pkg::*;
(
    input  psc_rot_req_t      req,
    output logic [CHAR_W-1:0] char_out
);

    logic             upper;
    logic             lower;
    logic [CHAR_W-1:0] base;
    logic [CHAR_W-1:0] off8;
    logic [5:0]       sum;
    logic [5:0]       wrapped;

    always_comb begin
        upper   = req.ch inside {[ASCII_UPPER_A:ASCII_UPPER_Z]};
        lower   = req.ch inside {[ASCII_LOWER_A:ASCII_LOWER_Z]};
        base    = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
        off8    = req.ch - base;
        // off and shift are both below 26, so one conditional subtract wraps
        if (req.decrypt) begin
            sum = off8[5:0] + ALPHABET - 6'(req.shift);
        end else begin
            sum = off8[5:0] + 6'(req.shift);
        end
        wrapped = (sum >= ALPHABET) ? (sum - ALPHABET) : sum;
        if (upper || lower) begin
            char_out = base + 8'(wrapped);
        end else begin
            char_out = req.ch;
        end
    end

endmodule

>>> hw/rtl/polyalphabetic_shift_cipher_top.sv
// Top level of the polyalphabetic shift cipher: command decode, key tracking, pipeline.
// Usage
//   Input items arrive on the s_ stream. s_tuser carries the command: process a
//   character, write a shift table entry, write a key sequence entry, or restart
//   the key position. Only character items give a result item on the m_ stream
//   (one byte, a rotated letter or the unchanged byte); the other commands give
//   nothing. Mode (encrypt/decrypt) and the sequence length are set through the
//   cfg_ write port while no item is in flight.
// Timing
//   Three stages, in order: input register with the key sequence read, shift
//   table read, result register, which drives m_tdata. One item per cycle is
//   sustained while m_tready is high; each memory is touched in a single stage,
//   so writes and reads stay in stream order with no stalls.
// Reset
//   aresetn (synchronous, active low) empties the pipeline, sets the key
//   position to 0, mode to encrypt and sequence length to 1. Both tables keep
//   their contents and must be written before use; there is no clearing pass.
// Backpressure
//   While m_tready is low the result register holds; earlier stages keep
//   collapsing bubbles, so s_tready drops only when every stage is occupied.
module polyalphabetic_shift_cipher_top
    import psc_pkg::*;
#(
    parameter int SHIFT_ENTRIES    = DEF_SHIFT_ENTRIES,
    parameter int SEQUENCE_ENTRIES = DEF_SEQUENCE_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: entry_index[5:0], entry_value[13:6], char_in[21:14], zero pad [23:22]
    input  logic [23:0] s_tdata,
    // s_tuser: cmd[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: char_out[7:0]
    output logic [7:0]  m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int SH_AW = (SHIFT_ENTRIES > 1) ? $clog2(SHIFT_ENTRIES) : 1;
    localparam int PW    = (SEQUENCE_ENTRIES > 1) ? $clog2(SEQUENCE_ENTRIES) : 1;
    localparam int LEN_W = ($clog2(SEQUENCE_ENTRIES + 1) > LEN_CFG_W) ?
                           $clog2(SEQUENCE_ENTRIES + 1) : LEN_CFG_W;

    // ---------------- input field split ----------------
    cmd_t               in_cmd;
    logic [5:0]         in_idx;
    logic signed [7:0]  in_val;
    logic [CHAR_W-1:0]  in_ch;
    logic               in_letter;
    logic               accept;

    assign in_cmd = cmd_t'(s_tuser);
    assign in_idx = s_tdata[5:0];
    assign in_val = s_tdata[13:6];
    assign in_ch  = s_tdata[21:14];
    assign accept = s_tvalid && s_tready;

    always_comb begin
        in_letter = (in_ch inside {[ASCII_UPPER_A:ASCII_UPPER_Z]}) ||
                    (in_ch inside {[ASCII_LOWER_A:ASCII_LOWER_Z]});
    end

    // ---------------- configuration ----------------
    logic                 decrypt_reg;
    logic [LEN_CFG_W-1:0] seq_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decrypt_reg <= 1'b0;
            seq_len_reg <= LEN_CFG_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_DECRYPT: decrypt_reg <= cfg_wdata[0];
                CFG_SEQ_LEN: seq_len_reg <= cfg_wdata[LEN_CFG_W-1:0];
                default:     decrypt_reg <= decrypt_reg;
            endcase
        end
    end

    // ---------------- key position ----------------
    // Zero length acts as one, too long clamps to the sequence depth. A position
    // left beyond a lowered length is used once and then wraps.
    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] pos_inc;
    logic [PW-1:0]    key_pos_reg;
    logic [PW-1:0]    key_pos_next;

    always_comb begin
        if (seq_len_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (LEN_W'(seq_len_reg) > LEN_W'(SEQUENCE_ENTRIES)) begin
            eff_len = LEN_W'(SEQUENCE_ENTRIES);
        end else begin
            eff_len = LEN_W'(seq_len_reg);
        end
        pos_inc      = LEN_W'(key_pos_reg) + LEN_W'(1);
        key_pos_next = key_pos_reg;
        if (accept) begin
            case (in_cmd)
                CMD_RESTART: key_pos_next = '0;
                CMD_CHAR: begin
                    if (in_letter) begin
                        key_pos_next = (pos_inc >= eff_len) ? '0 : pos_inc[PW-1:0];
                    end
                end
                default: key_pos_next = key_pos_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_pos_reg <= '0;
        end else begin
            key_pos_reg <= key_pos_next;
        end
    end

    // ---------------- pipeline control ----------------
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic mv_reg, mv_next;
    cmd_t cmd1_reg;
    logic out_load;
    logic st2_free;
    logic st1_move;
    logic st1_to_st2;

    assign out_load   = v2_reg && (!mv_reg || m_tready);
    assign st2_free   = !v2_reg || out_load;
    assign st1_move   = v1_reg && ((cmd1_reg != CMD_CHAR) || st2_free);
    assign st1_to_st2 = st1_move && (cmd1_reg == CMD_CHAR);
    assign s_tready   = !v1_reg || st1_move;

    always_comb begin
        v1_next = accept ? 1'b1 : (st1_move ? 1'b0 : v1_reg);
        v2_next = st1_to_st2 ? 1'b1 : (out_load ? 1'b0 : v2_reg);
        mv_next = out_load ? 1'b1 : ((mv_reg && m_tready) ? 1'b0 : mv_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            mv_reg <= mv_next;
        end
    end

    // ---------------- stage 1: key sequence access ----------------
    logic [5:0]        idx1_reg;
    logic signed [7:0] val1_reg;
    logic [CHAR_W-1:0] ch1_reg;
    logic [SLOT_W-1:0] slot1;
    logic              ks_we;
    logic              ks_re;

    assign ks_we = accept && (in_cmd == CMD_SEQ) && (32'(in_idx) < SEQUENCE_ENTRIES);
    assign ks_re = accept && (in_cmd == CMD_CHAR);

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd1_reg <= in_cmd;
            idx1_reg <= in_idx;
            val1_reg <= in_val;
            ch1_reg  <= in_ch;
        end
    end

    psc_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SEQUENCE_ENTRIES)
    ) u_key_seq (
        .aclk  (aclk),
        .we    (ks_we),
        .waddr (PW'(in_idx)),
        .wdata (in_val[SLOT_W-1:0]),
        .re    (ks_re),
        .raddr (key_pos_reg),
        .rdata (slot1)
    );

    // ---------------- stage 2: shift table access ----------------
    logic              sh_we;
    logic [SHIFT_W-1:0] sh_wdata;
    logic [SHIFT_W-1:0] sh_rdata;
    logic [CHAR_W-1:0] ch2_reg;
    logic              zero2_reg;
    logic              decrypt2_reg;

    assign sh_we    = st1_move && (cmd1_reg == CMD_SHIFT) &&
                      (32'(idx1_reg) < SHIFT_ENTRIES);
    assign sh_wdata = mod26(val1_reg);

    always_ff @(posedge aclk) begin
        if (st1_to_st2) begin
            ch2_reg      <= ch1_reg;
            zero2_reg    <= !(32'(slot1) < SHIFT_ENTRIES);
            decrypt2_reg <= decrypt_reg;
        end
    end

    psc_ram #(
        .WIDTH (SHIFT_W),
        .DEPTH (SHIFT_ENTRIES)
    ) u_shift_tab (
        .aclk  (aclk),
        .we    (sh_we),
        .waddr (SH_AW'(idx1_reg)),
        .wdata (sh_wdata),
        .re    (st1_to_st2),
        .raddr (SH_AW'(slot1)),
        .rdata (sh_rdata)
    );

    // ---------------- rotation and result register ----------------
    psc_rot_req_t      rot_req;
    logic [CHAR_W-1:0] rot_char;
    logic [CHAR_W-1:0] m_data_reg;

    always_comb begin
        rot_req.ch      = ch2_reg;
        rot_req.shift   = zero2_reg ? '0 : sh_rdata;
        rot_req.decrypt = decrypt2_reg;
    end

    psc_rotate u_rotate (
        .req      (rot_req),
        .char_out (rot_char)
    );

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= rot_char;
        end
    end

    assign m_tdata  = m_data_reg;
    assign m_tvalid = mv_reg;

    // ---------------- assertions ----------------
    // Restart always brings the key position back to the first entry.
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (in_cmd == CMD_RESTART) |=> key_pos_reg == '0)
        else $error("key position not cleared by restart");

    // An empty input stage never back-pressures the source.
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !v1_reg |-> s_tready)
        else $error("s_tready low with empty input stage");

    // A finished item in stage 2 moves into an empty result register at once.
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && !mv_reg |=> mv_reg)
        else $error("stage 2 item not moved to result register");

    // Without an accepted item the key position holds.
    a_pos_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(key_pos_reg))
        else $error("key position moved without an item");

endmodule

>>> bench/polyalphabetic_shift_cipher_top_tb.sv
// Self-checking testbench for the polyalphabetic shift cipher top level.
module polyalphabetic_shift_cipher_top_tb
    import psc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Tracks table, key and mode state as items are accepted, and queues the
    // character each character item should come back as.
    class cipher_tracker;
        localparam int N_LETTERS = ALPHABET;

        logic [SHIFT_W-1:0] shift_amt [DEF_SHIFT_ENTRIES];
        logic [SLOT_W-1:0]  key_slot  [DEF_SEQUENCE_ENTRIES];
        bit                 shift_ok  [DEF_SHIFT_ENTRIES];
        bit                 key_ok    [DEF_SEQUENCE_ENTRIES];
        int                 key_ptr;
        bit                 decrypting;
        logic [LEN_CFG_W-1:0] key_len;
        logic [CHAR_W-1:0]  pending_chars [$];
        int                 errors;
        int                 results;

        function new();
            foreach (shift_ok[i]) shift_ok[i] = 1'b0;
            foreach (key_ok[i]) key_ok[i] = 1'b0;
            key_ptr    = 0;
            decrypting = 1'b0;
            key_len    = 7'd1;
            errors     = 0;
            results    = 0;
        endfunction

        function bit is_letter(logic [CHAR_W-1:0] ch);
            return (ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_Z) ||
                   (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z);
        endfunction

        // True when a letter sent now would only read written entries.
        function bit can_cipher();
            return key_ok[key_ptr] && shift_ok[key_slot[key_ptr]];
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction

        function void set_reg(cfg_idx_t r, logic [CFG_W-1:0] v);
            if (r == CFG_DECRYPT) decrypting = v[0];
            else key_len = v;
        endfunction

        function void take_item(cmd_t c, logic [SLOT_W-1:0] idx, logic [7:0] val,
                                logic [CHAR_W-1:0] ch);
            int sv;
            int span;
            int s;
            int off;
            logic [CHAR_W-1:0] base;
            logic [CHAR_W-1:0] res;
            case (c)
                CMD_SHIFT: begin
                    sv = $signed(val);
                    shift_amt[idx] = SHIFT_W'(((sv % N_LETTERS) + N_LETTERS) % N_LETTERS);
                    shift_ok[idx]  = 1'b1;
                end
                CMD_SEQ: begin
                    key_slot[idx] = val[SLOT_W-1:0];
                    key_ok[idx]   = 1'b1;
                end
                CMD_RESTART: key_ptr = 0;
                default: begin
                    res = ch;
                    if (is_letter(ch)) begin
                        base = (ch <= ASCII_UPPER_Z) ? ASCII_UPPER_A : ASCII_LOWER_A;
                        s    = shift_amt[key_slot[key_ptr]];
                        off  = int'(ch) - int'(base);
                        if (decrypting) off = (off + N_LETTERS - s) % N_LETTERS;
                        else off = (off + s) % N_LETTERS;
                        res  = base + CHAR_W'(off);
                        span = int'(key_len);
                        if (span == 0) span = 1;
                        if (span > DEF_SEQUENCE_ENTRIES) span = DEF_SEQUENCE_ENTRIES;
                        // a pointer left beyond a lowered length wraps here
                        key_ptr = (key_ptr + 1 >= span) ? 0 : key_ptr + 1;
                    end
                    pending_chars.insert(pending_chars.size(), res);
                end
            endcase
        endfunction

        function void match_char(logic [CHAR_W-1:0] got);
            logic [CHAR_W-1:0] want;
            results++;
            if (pending_chars.size() == 0) begin
                errors++;
                $display("%0t: unexpected output item: expected none, actual %h", $time, got);
                return;
            end
            want = pending_chars.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: char_out mismatch: expected %h, actual %h", $time, want, got);
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic [23:0]        s_tdata = '0;
    logic [1:0]         s_tuser = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         m_tdata;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [0:0]         cfg_addr = '0;
    logic [CFG_W-1:0]   cfg_wdata = '0;

    cipher_tracker      sb = new();
    bit                 quiet = 1'b0;   // no new pauses on either side while set
    int                 sent = 0;
    int                 hold = 0;

    polyalphabetic_shift_cipher_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    // Pause length: mostly short, now and then a long one.
    function automatic int pause_len();
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_gap();
        if (quiet || $urandom_range(0, 99) < 65) return 0;
        return pause_len();
    endfunction

    // Result side backpressure: one assignment per edge, low while hold runs.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold > 0) hold--;
            else if (!quiet && $urandom_range(0, 99) < 15) hold = pause_len();
            m_tready <= (hold == 0);
        end
    end

    // Sample results before any update of this edge lands.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.match_char(m_tdata);
    end

    // One input item. Valid stays high across back-to-back items and only
    // drops when a gap is inserted. Returns right after the accepting edge.
    task automatic send_item(cmd_t c, logic [5:0] idx, logic [7:0] val, logic [7:0] ch);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {2'b00, ch, val, idx};
        do @(posedge aclk); while (!s_tready);
        sb.take_item(c, idx, val, ch);
        sent++;
    endtask

    // Character item. Before a letter, any key or shift entry it would read
    // that was never written gets written first.
    task automatic send_char(logic [7:0] ch);
        if (sb.is_letter(ch)) begin
            while (!sb.can_cipher()) begin
                if (!sb.key_ok[sb.key_ptr])
                    send_item(CMD_SEQ, 6'(sb.key_ptr), 8'($urandom), 8'($urandom));
                else
                    send_item(CMD_SHIFT, sb.key_slot[sb.key_ptr], 8'($urandom),
                              8'($urandom));
            end
        end
        send_item(CMD_CHAR, 6'($urandom), 8'($urandom), ch);
    endtask

    // Register write, only with the pipeline drained. Non-character items
    // give no result, so the task also waits past the last result for them.
    task automatic write_reg(cfg_idx_t r, logic [CFG_W-1:0] v);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.set_reg(r, v);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [7:0] random_letter();
        if ($urandom_range(0, 1)) return ASCII_UPPER_A + 8'($urandom_range(0, 25));
        return ASCII_LOWER_A + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [CFG_W-1:0] random_len();
        case ($urandom_range(0, 7))
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd64;
            3: return 7'd127;
            4: return 7'($urandom_range(65, 127));
            default: return 7'($urandom_range(1, 64));
        endcase
    endfunction

    // Key load: a run of sequence entries, each pointing at a shift entry
    // that is written too, then length, mode and a restart.
    task automatic load_key();
        int len;
        int r;
        logic [5:0] slot;
        r = $urandom_range(0, 9);
        if (r < 6) len = $urandom_range(1, 8);
        else if (r < 9) len = $urandom_range(9, 63);
        else len = 64;
        for (int p = 0; p < len; p++) begin
            slot = 6'($urandom);
            send_item(CMD_SEQ, 6'(p), {2'($urandom), slot}, 8'($urandom));
            if (!sb.shift_ok[slot] || $urandom_range(0, 1))
                send_item(CMD_SHIFT, slot, 8'($urandom), 8'($urandom));
        end
        write_reg(CFG_SEQ_LEN, ($urandom_range(0, 9) < 7) ? 7'(len) : random_len());
        write_reg(CFG_DECRYPT, 7'($urandom));
        send_item(CMD_RESTART, 6'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Mostly letters, with other bytes, restarts and stray writes mixed in.
    task automatic send_text();
        int n;
        int r;
        n = $urandom_range(8, 40);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 75) send_char(random_letter());
            else if (r < 88) send_char(8'($urandom));
            else if (r < 92) send_item(CMD_RESTART, 6'($urandom), 8'($urandom), 8'($urandom));
            else if (r < 96) send_item(CMD_SHIFT, 6'($urandom), 8'($urandom), 8'($urandom));
            else send_item(CMD_SEQ, 6'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        int start;
        int kind;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: shift extremes (-128, 127, -1, 0), both index ends, a
        // sequence value with high bits set.
        send_item(CMD_SHIFT, 6'd0, 8'h80, 8'h00);
        send_item(CMD_SHIFT, 6'd63, 8'h7F, 8'hFF);
        send_item(CMD_SHIFT, 6'd1, 8'hFF, 8'h55);
        send_item(CMD_SHIFT, 6'd2, 8'h00, 8'hAA);
        send_item(CMD_SEQ, 6'd0, 8'h00, 8'h00);
        send_item(CMD_SEQ, 6'd1, 8'hFF, 8'hFF);
        send_item(CMD_SEQ, 6'd63, 8'h41, 8'h12);
        send_item(CMD_SEQ, 6'd2, 8'h02, 8'h34);
        // letter ends of both cases, then the bytes just outside them
        send_char(ASCII_UPPER_A);
        send_char(ASCII_UPPER_Z);
        send_char(ASCII_LOWER_A);
        send_char(ASCII_LOWER_Z);
        send_char(ASCII_UPPER_A - 8'd1);
        send_char(ASCII_UPPER_Z + 8'd1);
        send_char(ASCII_LOWER_A - 8'd1);
        send_char(ASCII_LOWER_Z + 8'd1);
        send_char(8'h00);
        send_char(8'hFF);
        // length 3, step the pointer to 2, then lower the length under it
        write_reg(CFG_SEQ_LEN, 7'd3);
        send_char("b");
        send_char("y");
        write_reg(CFG_SEQ_LEN, 7'd1);
        write_reg(CFG_DECRYPT, {6'($urandom), 1'b1});
        send_char("M");
        send_char("q");
        // length 0 acts as 1, length 127 as the full sequence
        write_reg(CFG_SEQ_LEN, 7'd0);
        send_item(CMD_RESTART, 6'd63, 8'hFF, 8'hFF);
        send_char("c");
        write_reg(CFG_SEQ_LEN, 7'd127);
        write_reg(CFG_DECRYPT, {6'($urandom), 1'b0});
        send_char("N");

        // Random phases: key loads followed by text, bare register changes,
        // and text on whatever key is current.
        start = sent;
        while (sent - start < 500) begin
            kind  = $urandom_range(0, 9);
            quiet = ($urandom_range(0, 4) == 0);
            if (kind < 4) begin
                load_key();
                send_text();
            end else if (kind < 6) begin
                if ($urandom_range(0, 1)) write_reg(CFG_DECRYPT, 7'($urandom));
                write_reg(CFG_SEQ_LEN, random_len());
            end else begin
                send_text();
            end
        end
        quiet = 1'b0;

        // Drain: every queued character must come back, then a margin.
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d items; %0d output characters compared.", sent, sb.results);
        $display("Covered both modes, key lengths 0..127 and table writes of every kind.");
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
